// ===== src/sse_pkg.sv =====
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types, constants and lookup functions of the four-channel shaped
// slew generator: item structs, step request/response, register indexes.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int VOLT_BITS    = 20;
    localparam int SHAPE_BITS   = 16;
    localparam int PULSE_BITS   = 16;
    localparam int STEP_BITS    = 27;
    localparam int DIST_BITS    = 20;
    localparam int CHANNELS_DEF = 4;

    localparam logic signed [VOLT_BITS-1:0] TEN_VOLTS   = VOLT_BITS'(327680);
    localparam logic signed [VOLT_BITS-1:0] ONE_VOLT    = VOLT_BITS'(32768);
    localparam logic signed [VOLT_BITS-1:0] CYCLE_VOLTS = VOLT_BITS'(131072);

    localparam logic [14:0] LOG_W   = 15'd31130;
    localparam logic [14:0] EXP_W   = 15'd29491;
    localparam logic [14:0] E_TENTH = 15'd17815;

    localparam logic [15:0] SAMPLE_TIME_RST = 16'd683;
    localparam logic [15:0] PULSE_RST       = 16'd48;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_RANGE       = 3'd0,
        CFG_LOGIC       = 3'd1,
        CFG_B_AMOUNT    = 3'd2,
        CFG_C_AMOUNT    = 3'd3,
        CFG_SAMPLE_TIME = 3'd4,
        CFG_PULSE       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]                   channel;
        logic signed [VOLT_BITS-1:0]  in_sample;
        logic signed [VOLT_BITS-1:0]  trig_level;
        logic signed [VOLT_BITS-1:0]  ext_trig_level;
        logic signed [VOLT_BITS-1:0]  rise_ctl;
        logic signed [VOLT_BITS-1:0]  fall_ctl;
        logic signed [VOLT_BITS-1:0]  cycle_ctl;
        logic signed [SHAPE_BITS-1:0] shape_ctl;
    } t_in_item;

    typedef struct packed {
        logic signed [VOLT_BITS-1:0] slew_out;
        logic                        end_of_cycle;
        logic                        is_rising;
        logic                        is_falling;
        logic                        pair_valid;
        logic signed [VOLT_BITS-1:0] pair_sum;
        logic signed [VOLT_BITS-1:0] pair_select;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                   range_sel;
        logic signed [VOLT_BITS-1:0]  ctl;
        logic [DIST_BITS-1:0]         span;
        logic signed [SHAPE_BITS-1:0] shape;
    } t_step_req;

    typedef struct packed {
        logic                 done;
        logic [STEP_BITS-1:0] step;
    } t_step_rsp;

    // 2^(-k/16) in Q16
    function automatic logic [16:0] pow_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    // Rate factor per time range: 10 ms, 1 ms, 100 ms
    function automatic logic [13:0] range_k(input logic [1:0] sel);
        logic [13:0] k;
        case (sel)
            2'd0:    k = 14'd1000;
            2'd1:    k = 14'd10000;
            default: k = 14'd100;
        endcase
        return k;
    endfunction

    // Schmitt trigger: returns {next armed, fire}
    function automatic logic [1:0] schmitt_next(input logic armed,
                                                input logic signed [VOLT_BITS-1:0] lvl);
        logic [1:0] r;
        if (armed) begin
            r = {!(lvl <= $signed(VOLT_BITS'(0))), 1'b0};
        end else if (lvl >= ONE_VOLT) begin
            r = 2'b11;
        end else begin
            r = 2'b00;
        end
        return r;
    endfunction

endpackage

// ===== src/shaped_slew_envelope_quad.sv =====
// ----------------------------------------------------------------------------
// shaped_slew_envelope_quad
// Four-channel shaped slew generator with end-of-cycle pulses and pair
// sum / max-min outputs; per-channel state held in a small synchronous RAM.
//
//   port group   direction  handshake                    payload
//   in item      input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
//   out item     output     o_out_valid / i_out_ready    o_out_data (t_out_item)
//   config       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One item at a time; an item whose output already sits on its target skips the
// step unit, and a logarithmic shape takes longer than a linear/exponential one,
// set by the one-bit-per-cycle divider in the step unit.
// A finished item waits in the output register while the next item is taken.
// Synchronous active-low reset; state RAM entries read zero until written.
// ----------------------------------------------------------------------------
module shaped_slew_envelope_quad
    import sse_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PAIRS   = (CHANNELS + 1) / 2;
    localparam int PW      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int ENTRY_W = VOLT_BITS + PULSE_BITS;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_RD_SELF = 8'b0000_0010,
        ST_RD_PART = 8'b0000_0100,
        ST_EVAL    = 8'b0000_1000,
        ST_STEP    = 8'b0001_0000,
        ST_UPDATE  = 8'b0010_0000,
        ST_PAIR    = 8'b0100_0000,
        ST_FIN     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [7:0]  r_range;
    logic [1:0]  r_logic;
    logic [15:0] r_b_amount;
    logic [15:0] r_c_amount;
    logic [15:0] r_sample_time;
    logic [15:0] r_pulse_samples;

    // Per-channel flags
    logic [CHANNELS-1:0] r_gate;
    logic [CHANNELS-1:0] r_armed;
    logic [PAIRS-1:0]    r_ext_armed;

    // Item context
    t_in_item                    r_item;
    logic signed [VOLT_BITS-1:0] r_cur;
    logic [PULSE_BITS-1:0]       r_pulse;
    logic signed [VOLT_BITS-1:0] r_part;
    logic signed [VOLT_BITS-1:0] r_target;
    logic                        r_dir_up;
    logic                        r_dir_dn;
    logic                        r_gate_c;
    logic [STEP_BITS-1:0]        r_step;
    logic signed [VOLT_BITS-1:0] r_next;
    logic                        r_rising;
    logic                        r_falling;
    logic                        r_eoc;
    logic signed [36:0]          r_prod;
    logic signed [VOLT_BITS-1:0] r_addend;

    logic      r_out_valid;
    t_out_item r_out;

    // Addressing
    logic [AW+1:0] w_ch_ext;
    logic [AW+1:0] w_part_ext;
    logic [AW+1:0] w_in_ext;
    logic [AW-1:0] w_self;
    logic [AW-1:0] w_part;
    logic [PW:0]   w_pair_ext;
    logic [PW-1:0] w_pair;
    logic          w_unused;
    logic          w_has_part;
    logic          w_even;

    assign w_ch_ext   = (AW + 2)'(r_item.channel);
    assign w_part_ext = w_ch_ext + (AW + 2)'(1);
    assign w_in_ext   = (AW + 2)'(i_in_data.channel);
    assign w_self     = w_ch_ext[AW-1:0];
    assign w_part     = w_part_ext[AW-1:0];
    assign w_pair_ext = (PW + 1)'(r_item.channel[1]);
    assign w_pair     = w_pair_ext[PW-1:0];
    assign w_unused   = 6'(r_item.channel) >= 6'(CHANNELS);
    assign w_has_part = (6'(r_item.channel) + 6'd1) < 6'(CHANNELS);
    assign w_even     = !r_item.channel[0];

    // State memory
    logic               w_mem_we;
    logic [ENTRY_W-1:0] w_mem_wdata;
    logic               w_mem_re;
    logic [AW-1:0]      w_mem_raddr;
    logic [ENTRY_W-1:0] w_mem_rdata;
    logic               w_accept;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_mem_re    = w_accept || (r_state == ST_RD_SELF);
    assign w_mem_raddr = (r_state == ST_RD_SELF) ? w_part : w_in_ext[AW-1:0];

    sse_state_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_mem_we),
        .i_waddr (w_self),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Triggers, target and distance
    logic [1:0]                  w_ext_sch;
    logic [1:0]                  w_ch_sch;
    logic                        w_fire_ext;
    logic                        w_gate_c;
    logic signed [VOLT_BITS-1:0] w_target;
    logic signed [VOLT_BITS:0]   w_delta;
    logic                        w_up;
    logic                        w_dn;
    t_step_req                   w_req;
    t_step_rsp                   w_rsp;
    logic                        w_start;

    always_comb begin
        w_ext_sch  = schmitt_next(r_ext_armed[w_pair], r_item.ext_trig_level);
        w_ch_sch   = schmitt_next(r_armed[w_self], r_item.trig_level);
        w_fire_ext = w_even && w_ext_sch[0];
        w_gate_c   = r_gate[w_self] || w_fire_ext || w_ch_sch[0];
        w_target   = w_gate_c ? TEN_VOLTS : r_item.in_sample;
        w_delta    = (VOLT_BITS + 1)'(w_target) - (VOLT_BITS + 1)'(r_cur);
        w_dn       = w_delta[VOLT_BITS];
        w_up       = !w_delta[VOLT_BITS] && (w_delta != '0);
        w_req.range_sel = r_range[{r_item.channel, 1'b0} +: 2];
        w_req.ctl       = w_up ? r_item.rise_ctl : r_item.fall_ctl;
        w_req.span      = w_dn ? DIST_BITS'(-w_delta) : DIST_BITS'(w_delta);
        w_req.shape     = r_item.shape_ctl;
        w_start         = (r_state == ST_EVAL) && (w_up || w_dn);
    end

    sse_step_unit u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_req         (w_req),
        .i_sample_time (r_sample_time),
        .o_rsp         (w_rsp)
    );

    // Move, snap, gate and pulse
    logic signed [28:0]          w_cur_x;
    logic signed [28:0]          w_tgt_x;
    logic signed [28:0]          w_step_x;
    logic signed [28:0]          w_moved;
    logic                        w_rising;
    logic                        w_falling;
    logic                        w_fall_snap;
    logic signed [VOLT_BITS-1:0] w_next;
    logic [PULSE_BITS-1:0]       w_pulse_set;
    logic                        w_eoc;
    logic [PULSE_BITS-1:0]       w_pulse_dec;
    logic                        w_gate_fin;

    always_comb begin
        w_cur_x     = 29'(r_cur);
        w_tgt_x     = 29'(r_target);
        w_step_x    = $signed({2'b00, r_step});
        w_moved     = r_dir_up ? (w_cur_x + w_step_x) : (w_cur_x - w_step_x);
        w_rising    = r_dir_up && ((w_tgt_x - w_moved) > 29'sd32);
        w_falling   = r_dir_dn && ((w_moved - w_tgt_x) > 29'sd32);
        w_next      = (w_rising || w_falling) ? w_moved[VOLT_BITS-1:0] : r_target;
        w_fall_snap = r_dir_dn && !w_falling;
        w_pulse_set = (w_fall_snap && (r_pulse < r_pulse_samples)) ? r_pulse_samples
                                                                   : r_pulse;
        w_eoc       = (w_pulse_set != '0);
        w_pulse_dec = w_eoc ? (w_pulse_set - PULSE_BITS'(1)) : w_pulse_set;
        if (r_dir_up && !w_rising) begin
            w_gate_fin = 1'b0;
        end else if (w_fall_snap && (r_item.cycle_ctl >= CYCLE_VOLTS)) begin
            w_gate_fin = 1'b1;
        end else if (!r_dir_up && !r_dir_dn) begin
            w_gate_fin = 1'b0;
        end else begin
            w_gate_fin = r_gate_c;
        end
        w_mem_we    = (r_state == ST_UPDATE);
        w_mem_wdata = {w_next, w_pulse_dec};
    end

    // Pair product, rounding and saturation
    logic signed [VOLT_BITS-1:0] w_mul_val;
    logic [15:0]                 w_weight;
    logic signed [36:0]          w_prod;
    logic signed [37:0]          w_round;
    logic signed [23:0]          w_sum;
    logic signed [VOLT_BITS-1:0] w_sum_sat;
    logic signed [VOLT_BITS-1:0] w_pick;
    logic                        w_pair_valid;
    logic                        w_load;
    t_out_item                   w_out;

    always_comb begin
        w_mul_val = r_item.channel[1] ? r_next : r_part;
        w_weight  = r_item.channel[1] ? r_c_amount : r_b_amount;
        w_prod    = 37'(w_mul_val) * $signed({1'b0, w_weight});
        w_round   = (38'(r_prod) + 38'sd16384) >>> 15;
        w_sum     = 24'(r_addend) + $signed(w_round[23:0]);
        if (w_sum > 24'sd524287) begin
            w_sum_sat = VOLT_BITS'(524287);
        end else if (w_sum < -24'sd524288) begin
            w_sum_sat = VOLT_BITS'(-524288);
        end else begin
            w_sum_sat = w_sum[VOLT_BITS-1:0];
        end
        if (r_logic[r_item.channel[1]]) begin
            w_pick = (r_next > r_part) ? r_part : r_next;
        end else begin
            w_pick = (r_next > r_part) ? r_next : r_part;
        end
        w_pair_valid = !w_unused && w_even && w_has_part;

        w_out = '0;
        if (!w_unused) begin
            w_out.slew_out     = r_next;
            w_out.end_of_cycle = r_eoc;
            w_out.is_rising    = r_rising;
            w_out.is_falling   = r_falling;
            w_out.pair_valid   = w_pair_valid;
            if (w_pair_valid) begin
                w_out.pair_sum    = w_sum_sat;
                w_out.pair_select = w_pick;
            end
        end
        w_load = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);
    end

    // Control sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (w_accept) n_state = ST_RD_SELF;
            ST_RD_SELF: n_state = w_unused ? ST_FIN : ST_RD_PART;
            ST_RD_PART: n_state = ST_EVAL;
            ST_EVAL:    n_state = w_start ? ST_STEP : ST_UPDATE;
            ST_STEP:    if (w_rsp.done) n_state = ST_UPDATE;
            ST_UPDATE:  n_state = ST_PAIR;
            ST_PAIR:    n_state = ST_FIN;
            ST_FIN:     if (w_load) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range         <= '0;
            r_logic         <= '0;
            r_b_amount      <= '0;
            r_c_amount      <= '0;
            r_sample_time   <= SAMPLE_TIME_RST;
            r_pulse_samples <= PULSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RANGE:       r_range         <= i_cfg_data[7:0];
                CFG_LOGIC:       r_logic         <= i_cfg_data[1:0];
                CFG_B_AMOUNT:    r_b_amount      <= i_cfg_data;
                CFG_C_AMOUNT:    r_c_amount      <= i_cfg_data;
                CFG_SAMPLE_TIME: r_sample_time   <= i_cfg_data;
                CFG_PULSE:       r_pulse_samples <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Trigger and gate flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= '0;
            r_armed     <= '0;
            r_ext_armed <= '0;
        end else if (r_state == ST_EVAL) begin
            if (w_even) r_ext_armed[w_pair] <= w_ext_sch[1];
            r_armed[w_self] <= w_ch_sch[1];
            r_gate[w_self]  <= w_gate_c;
            if (w_fire_ext && w_has_part) r_gate[w_part] <= 1'b1;
        end else if (r_state == ST_UPDATE) begin
            r_gate[w_self] <= w_gate_fin;
        end
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) r_item <= i_in_data;
            end
            ST_RD_SELF: begin
                r_cur   <= w_mem_rdata[ENTRY_W-1:PULSE_BITS];
                r_pulse <= w_mem_rdata[PULSE_BITS-1:0];
            end
            ST_RD_PART: begin
                r_part <= w_mem_rdata[ENTRY_W-1:PULSE_BITS];
            end
            ST_EVAL: begin
                r_target <= w_target;
                r_dir_up <= w_up;
                r_dir_dn <= w_dn;
                r_gate_c <= w_gate_c;
            end
            ST_STEP: begin
                if (w_rsp.done) r_step <= w_rsp.step;
            end
            ST_UPDATE: begin
                r_next    <= w_next;
                r_rising  <= w_rising;
                r_falling <= w_falling;
                r_eoc     <= w_eoc;
            end
            ST_PAIR: begin
                r_prod   <= w_prod;
                r_addend <= r_item.channel[1] ? r_part : r_next;
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_out <= w_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_accept_reads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_RD_SELF))
        else $error("accepted item did not start a state read");

    a_no_unused_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !w_unused)
        else $error("state write for a channel beyond the configured count");

    a_dir_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.is_rising && o_out_data.is_falling))
        else $error("output reports rising and falling together");

    a_step_only_in_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_STEP))
        else $error("step result arrived outside the step wait");

endmodule

// ===== src/sse_state_ram.sv =====
// ----------------------------------------------------------------------------
// sse_state_ram
// Per-channel state memory (output value and pulse count), one write and one
// registered read port; per-entry valid bits make unwritten entries read zero.
// ----------------------------------------------------------------------------
module sse_state_ram
    import sse_pkg::*;
#(
    parameter int DEPTH = CHANNELS_DEF,
    parameter int WIDTH = VOLT_BITS + PULSE_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Track written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== src/sse_step_unit.sv =====
// ----------------------------------------------------------------------------
// sse_step_unit
// Step size sequencer: exponential time constant from table, linear/log/exp
// laws and crossfade, on one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module sse_step_unit
    import sse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_step_req   i_req,
    input  logic [15:0] i_sample_time,
    output t_step_rsp   o_rsp
);

    typedef enum logic [11:0] {
        SU_IDLE  = 12'b0000_0000_0001,
        SU_FRAC  = 12'b0000_0000_0010,
        SU_KST   = 12'b0000_0000_0100,
        SU_KSTM  = 12'b0000_0000_1000,
        SU_SHIFT = 12'b0000_0001_0000,
        SU_WGT   = 12'b0000_0010_0000,
        SU_EXP1  = 12'b0000_0100_0000,
        SU_EXP2  = 12'b0000_1000_0000,
        SU_DIV   = 12'b0001_0000_0000,
        SU_MIXA  = 12'b0010_0000_0000,
        SU_MIXB  = 12'b0100_0000_0000,
        SU_MIXC  = 12'b1000_0000_0000
    } t_su_state;

    localparam int DIV_STEPS = 47;

    t_su_state   r_state, n_state;
    t_step_req   r_req;
    logic [16:0] r_m;
    logic [29:0] r_r;
    logic [14:0] r_w;
    logic [34:0] r_other;
    logic [45:0] r_acc;
    logic [56:0] r_p;
    logic [20:0] r_rem;
    logic [46:0] r_quo;
    logic [5:0]  r_cnt;

    logic [15:0] w_cv;
    logic [18:0] w_e;
    logic [3:0]  w_ip;
    logic [4:0]  w_idx;
    logic [10:0] w_frac;
    logic [16:0] w_tab_lo;
    logic [16:0] w_diff;
    logic [15:0] w_mag;
    logic [14:0] w_wconst;
    logic [15:0] w_winv;
    logic [35:0] w_ma;
    logic [20:0] w_mb;
    logic [56:0] w_prod;
    logic [20:0] w_den;
    logic [21:0] w_trial;
    logic        w_ge;
    logic [20:0] w_rem_n;
    logic [46:0] w_quo_n;
    logic [51:0] w_mix;
    logic [STEP_BITS-1:0] w_step;

    // Clamp control to 0..1 and split 10*ctl into octave and fraction
    always_comb begin
        if (r_req.ctl[VOLT_BITS-1]) begin
            w_cv = '0;
        end else if (r_req.ctl > $signed(VOLT_BITS'(32768))) begin
            w_cv = 16'd32768;
        end else begin
            w_cv = r_req.ctl[15:0];
        end
        w_e      = {w_cv, 3'b000} + {2'b00, w_cv, 1'b0};
        w_ip     = w_e[18:15];
        w_idx    = {1'b0, w_e[14:11]};
        w_frac   = w_e[10:0];
        w_tab_lo = pow_tab(w_idx);
        w_diff   = w_tab_lo - pow_tab(w_idx + 5'd1);
        w_mag    = r_req.shape[SHAPE_BITS-1] ? 16'(-r_req.shape) : 16'(r_req.shape);
        w_wconst = r_req.shape[SHAPE_BITS-1] ? LOG_W : EXP_W;
        w_winv   = 16'(17'd32768 - {2'b00, r_w});
        w_den    = {1'b0, r_req.span} + 21'd32768;
    end

    // Shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            SU_FRAC: begin
                w_ma = 36'(w_diff);
                w_mb = 21'(w_frac);
            end
            SU_KST: begin
                w_ma = 36'(i_sample_time);
                w_mb = 21'(range_k(r_req.range_sel));
            end
            SU_KSTM: begin
                w_ma = 36'(r_p[29:0]);
                w_mb = 21'(r_m);
            end
            SU_SHIFT: begin
                w_ma = 36'(w_mag);
                w_mb = 21'(w_wconst);
            end
            SU_WGT: begin
                w_ma = 36'(r_r);
                w_mb = 21'(E_TENTH);
            end
            SU_EXP1: begin
                w_ma = 36'(r_p[44:16]);
                w_mb = 21'(r_req.span);
            end
            SU_MIXA: begin
                w_ma = 36'(r_r);
                w_mb = 21'(w_winv);
            end
            SU_MIXB: begin
                w_ma = 36'(r_other);
                w_mb = 21'(r_w);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // One restoring divide step
    always_comb begin
        w_trial = {r_rem, r_quo[46]};
        w_ge    = w_trial >= {1'b0, w_den};
        w_rem_n = w_ge ? 21'(w_trial - {1'b0, w_den}) : w_trial[20:0];
        w_quo_n = {r_quo[45:0], w_ge};
    end

    // Final crossfade with rounding, minimum of one step
    always_comb begin
        w_mix  = 52'(r_acc) + 52'(r_p[50:0]) + 52'(24'h80_0000);
        w_step = w_mix[50:24];
        if (w_step == '0) begin
            w_step = STEP_BITS'(1);
        end
    end

    // Sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            SU_IDLE:  if (i_start) n_state = SU_FRAC;
            SU_FRAC:  n_state = SU_KST;
            SU_KST:   n_state = SU_KSTM;
            SU_KSTM:  n_state = SU_SHIFT;
            SU_SHIFT: n_state = SU_WGT;
            SU_WGT:   n_state = r_req.shape[SHAPE_BITS-1] ? SU_DIV : SU_EXP1;
            SU_EXP1:  n_state = SU_EXP2;
            SU_EXP2:  n_state = SU_MIXA;
            SU_DIV:   if (r_cnt == 6'(DIV_STEPS - 1)) n_state = SU_MIXA;
            SU_MIXA:  n_state = SU_MIXB;
            SU_MIXB:  n_state = SU_MIXC;
            SU_MIXC:  n_state = SU_IDLE;
            default:  n_state = SU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_p <= w_prod;
        case (r_state)
            SU_IDLE: begin
                if (i_start) r_req <= i_req;
            end
            SU_KST: begin
                r_m <= w_tab_lo - 17'(r_p[27:11]);
            end
            SU_SHIFT: begin
                r_r <= 30'((r_p[46:0] >> 16) >> w_ip);
            end
            SU_WGT: begin
                r_w   <= r_p[29:15];
                r_rem <= '0;
                r_quo <= {r_r, 17'b0};
                r_cnt <= '0;
            end
            SU_EXP2: begin
                r_other <= r_p[49:15];
            end
            SU_DIV: begin
                r_rem <= w_rem_n;
                r_quo <= w_quo_n;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) r_other <= w_quo_n[34:0];
            end
            SU_MIXB: begin
                r_acc <= r_p[45:0];
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == SU_MIXC);
    assign o_rsp.step = w_step;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-channel shaped slew generator. A queue of
// items feeds a valid/ready driver; a mirror of the channel state predicts
// every result. A monitor checks results in order against that prediction,
// across several register settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import sse_pkg::*;

    localparam int    PHASE_ITEMS = 200;
    localparam int    N_PHASES    = 8;
    localparam int    DRAIN_CYC   = 100;
    localparam longint VMAX       = 524287;
    localparam longint VMIN       = -524288;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    shaped_slew_envelope_quad u_top (.*);

    // Register mirror
    logic [7:0]  rng_sel;
    logic [1:0]  min_mode;
    logic [15:0] b_wt;
    logic [15:0] c_wt;
    logic [15:0] smp_time;
    logic [15:0] pulse_len;

    // Channel state mirror
    longint      chan_level [4];
    bit          chan_gate  [4];
    bit          chan_armed [4];
    bit          pair_armed [2];
    int unsigned chan_pulse [4];

    t_in_item    pending_q  [$];
    t_out_item   expected_q [$];
    int          mism_cnt;
    int          idle_pct;
    int          stall_pct;
    int          hold_cyc;

    longint unsigned pow2_frac [17] = '{65536, 62757, 60097, 57549, 55109, 52773,
        50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

    // Schmitt trigger: update armed flag, return 1 on a rising crossing
    function automatic bit schmitt_fire(ref bit armed, input longint lvl);
        if (armed) begin
            if (lvl <= 0) armed = 0;
            return 0;
        end
        if (lvl >= 32768) begin
            armed = 1;
            return 1;
        end
        return 0;
    endfunction

    function automatic longint clip_volts(input longint v);
        return (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
    endfunction

    // Step size per sample from time range, control and shape crossfade
    function automatic longint unsigned slew_step(input int c, input longint ctl,
                                                  input longint unsigned span,
                                                  input longint shape);
        longint unsigned k, e, f, m, r, lin, other, w, mix, stp;
        int unsigned sel, ip, idx;
        sel = (rng_sel >> (2 * c)) & 3;
        k = (sel == 0) ? 1000 : ((sel == 1) ? 10000 : 100);
        if (ctl < 0) ctl = 0;
        if (ctl > 32768) ctl = 32768;
        e = ctl * 10;
        ip = e >> 15;
        f = e & 32767;
        idx = f >> 11;
        m = pow2_frac[idx] - (((pow2_frac[idx] - pow2_frac[idx+1]) * (f & 2047)) >> 11);
        r = (k * smp_time * m) >> (16 + ip);
        lin = r;
        if (shape < 0) begin
            other = (r << 17) / (span + 32768);
            w = ((-shape) * 31130) >> 15;
        end else begin
            other = (span * ((r * 17815) >> 16)) >> 15;
            w = (shape * 29491) >> 15;
        end
        if (other > (64'd1 << 40)) other = 64'd1 << 40;
        mix = lin * (32768 - w) + other * w;
        stp = (mix + (64'd1 << 23)) >> 24;
        return (stp == 0) ? 1 : stp;
    endfunction

    // Advance one channel by one sample and return the expected result
    function automatic t_out_item predict_slew(input t_in_item it);
        t_out_item o;
        int c, p;
        longint tgt, cur, span, nxt, a, b, sum, pick;
        bit rising, falling, eoc;
        o = '0;
        c = it.channel;
        p = c >> 1;
        rising = 0;
        falling = 0;
        if (c[0] == 0 && schmitt_fire(pair_armed[p], longint'(it.ext_trig_level))) begin
            chan_gate[c] = 1;
            chan_gate[c+1] = 1;
        end
        if (schmitt_fire(chan_armed[c], longint'(it.trig_level))) chan_gate[c] = 1;
        tgt = chan_gate[c] ? 327680 : longint'(it.in_sample);
        cur = chan_level[c];
        span = tgt - cur;
        nxt = cur;
        if (span > 0) begin
            nxt = cur + longint'(slew_step(c, it.rise_ctl, span, it.shape_ctl));
            rising = (tgt - nxt) > 32;
            if (!rising) chan_gate[c] = 0;
        end else if (span < 0) begin
            nxt = cur - longint'(slew_step(c, it.fall_ctl, -span, it.shape_ctl));
            falling = (nxt - tgt) > 32;
            if (!falling) begin
                if (chan_pulse[c] < pulse_len) chan_pulse[c] = pulse_len;
                if (longint'(it.cycle_ctl) >= 131072) chan_gate[c] = 1;
            end
        end else begin
            chan_gate[c] = 0;
        end
        if (!rising && !falling) nxt = tgt;
        chan_level[c] = nxt;
        eoc = chan_pulse[c] > 0;
        if (eoc) chan_pulse[c]--;
        o.slew_out = nxt[VOLT_BITS-1:0];
        o.end_of_cycle = eoc;
        o.is_rising = rising;
        o.is_falling = falling;
        if (c[0] == 0) begin
            a = chan_level[c];
            b = chan_level[c+1];
            if (p == 0) sum = a + ((b * longint'(b_wt) + 16384) >>> 15);
            else        sum = ((a * longint'(c_wt) + 16384) >>> 15) + b;
            if (min_mode[p]) pick = (a > b) ? b : a;
            else             pick = (a > b) ? a : b;
            sum = clip_volts(sum);
            o.pair_valid = 1;
            o.pair_sum = sum[VOLT_BITS-1:0];
            o.pair_select = pick[VOLT_BITS-1:0];
        end
        return o;
    endfunction

    // Pick a voltage near the interesting levels
    function automatic logic [19:0] pick_level();
        case ($urandom_range(5))
            0: return 20'sd0;
            1: return 20'sd163840;
            2: return -20'sd163840;
            3: return 20'sd327680;
            4: return 20'($urandom_range(65536)) - 20'sd32768;
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it = '0;
        it.channel = 2'($urandom_range(3));
        if ($urandom_range(99) < 12) begin
            // noise: every field fully random
            it.in_sample      = 20'($urandom);
            it.trig_level     = 20'($urandom);
            it.ext_trig_level = 20'($urandom);
            it.rise_ctl       = 20'($urandom);
            it.fall_ctl       = 20'($urandom);
            it.cycle_ctl      = 20'($urandom);
            it.shape_ctl      = 16'($urandom);
        end else begin
            it.in_sample      = pick_level();
            it.trig_level     = ($urandom_range(3) == 0) ? 20'sd65536 : 20'sd0;
            it.ext_trig_level = ($urandom_range(7) == 0) ? 20'sd65536 : 20'sd0;
            it.rise_ctl       = 20'($urandom_range(36000)) - 20'sd1600;
            it.fall_ctl       = 20'($urandom_range(36000)) - 20'sd1600;
            it.cycle_ctl      = $urandom_range(1) ? 20'sd163840 : 20'sd0;
            it.shape_ctl      = 16'($urandom);
        end
        return it;
    endfunction

    function automatic t_in_item make_item(input logic [1:0] ch, input longint x,
                                           input longint tr, input longint ex,
                                           input longint rc, input longint fc,
                                           input longint cy, input longint sh);
        t_in_item it;
        it.channel = ch;
        it.in_sample = x[19:0];
        it.trig_level = tr[19:0];
        it.ext_trig_level = ex[19:0];
        it.rise_ctl = rc[19:0];
        it.fall_ctl = fc[19:0];
        it.cycle_ctl = cy[19:0];
        it.shape_ctl = sh[15:0];
        return it;
    endfunction

    // Write one register and update the mirror when the write is driven
    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_RANGE:       rng_sel   = val[7:0];
            CFG_LOGIC:       min_mode  = val[1:0];
            CFG_B_AMOUNT:    b_wt      = val;
            CFG_C_AMOUNT:    c_wt      = val;
            CFG_SAMPLE_TIME: smp_time  = val;
            CFG_PULSE:       pulse_len = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_q.size() == 0 && expected_q.size() == 0 && !i_in_valid);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Time limit
    initial begin
        #(8 * 3000000);
        $display("== FAIL ==");
        $finish;
    end

    // Input driver: hold valid and data until accepted, predict on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) expected_q.push_back(predict_slew(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_data  <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_cyc > 0) hold_cyc <= hold_cyc - 1;
    end

    // Output ready: random stalls, forced low during a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= (hold_cyc == 0) && ($urandom_range(99) >= stall_pct);
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mism_cnt <= mism_cnt + 1;
                if (mism_cnt < 10) $display("unexpected item %p", o_out_data);
            end else begin
                exp_item = expected_q.pop_front();
                if (o_out_data.slew_out     !== exp_item.slew_out     ||
                    o_out_data.end_of_cycle !== exp_item.end_of_cycle ||
                    o_out_data.is_rising    !== exp_item.is_rising    ||
                    o_out_data.is_falling   !== exp_item.is_falling   ||
                    o_out_data.pair_valid   !== exp_item.pair_valid   ||
                    o_out_data.pair_sum     !== exp_item.pair_sum     ||
                    o_out_data.pair_select  !== exp_item.pair_select) begin
                    mism_cnt <= mism_cnt + 1;
                    if (mism_cnt < 10)
                        $display("mismatch: expected %p, got %p", exp_item, o_out_data);
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_RANGE;
        i_cfg_data = '0;
        mism_cnt   = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_cyc   = 0;
        rng_sel = 0; min_mode = 0; b_wt = 0; c_wt = 0;
        smp_time = SAMPLE_TIME_RST; pulse_len = PULSE_RST;
        for (int c = 0; c < 4; c++) begin
            chan_level[c] = 0; chan_gate[c] = 0; chan_armed[c] = 0; chan_pulse[c] = 0;
        end
        pair_armed[0] = 0;
        pair_armed[1] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero item, extremes, triggers, snap, pulse, retrigger
        pending_q.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_item(1, VMAX, 0, 0, 32768, 32768, 0, 32767));
        pending_q.push_back(make_item(1, VMIN, 0, 0, VMIN, VMAX, 0, -32768));
        pending_q.push_back(make_item(2, 0, 32768, 0, 0, 0, 0, 0));
        pending_q.push_back(make_item(2, 0, 32768, 0, 0, 0, VMAX, -32768));
        pending_q.push_back(make_item(2, 0, 0, 0, 0, 0, 131072, 0));
        pending_q.push_back(make_item(0, 0, 0, 32768, 0, 0, 0, 0));
        pending_q.push_back(make_item(1, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_item(0, 0, 32767, 32767, 0, 0, 0, 0));
        pending_q.push_back(make_item(3, 40, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_item(3, 0, 0, 0, 0, 0, 131071, 0));
        pending_q.push_back(make_item(3, 0, VMIN, VMIN, VMIN, VMIN, VMIN, -32768));
        pending_q.push_back(make_item(0, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 32767));
        pending_q.push_back(make_item(0, VMIN, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(make_item(2, 20, 0, -1, 16384, 16384, 0, 1));
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_RANGE, 16'h0055); cfg_write(CFG_LOGIC, 16'd0);
                    cfg_write(CFG_B_AMOUNT, 16'd32768); cfg_write(CFG_C_AMOUNT, 16'd0);
                    cfg_write(CFG_SAMPLE_TIME, 16'd65535); cfg_write(CFG_PULSE, 16'd1);
                end
                1: begin
                    cfg_write(CFG_RANGE, 16'h00FF); cfg_write(CFG_LOGIC, 16'd3);
                    cfg_write(CFG_B_AMOUNT, 16'd0); cfg_write(CFG_C_AMOUNT, 16'd32768);
                    cfg_write(CFG_SAMPLE_TIME, 16'd65535); cfg_write(CFG_PULSE, 16'd3);
                end
                2: begin
                    cfg_write(CFG_RANGE, 16'h0000); cfg_write(CFG_SAMPLE_TIME, 16'd1);
                    cfg_write(CFG_PULSE, 16'd65535);
                end
                default: begin
                    cfg_write(CFG_RANGE, 16'($urandom_range(255)) | 16'h0011);
                    cfg_write(CFG_LOGIC, 16'($urandom_range(3)));
                    cfg_write(CFG_B_AMOUNT, 16'($urandom_range(32768)));
                    cfg_write(CFG_C_AMOUNT, 16'($urandom_range(32768)));
                    cfg_write(CFG_SAMPLE_TIME, 16'($urandom_range(65535, 4000)));
                    cfg_write(CFG_PULSE, 16'($urandom_range(8, 1)));
                end
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            // Hold the receiver off while the sender keeps offering items
            if (ph == 4) hold_cyc = 400;
            for (int n = 0; n < PHASE_ITEMS; n++) pending_q.push_back(rand_item());
            wait_idle();
        end

        if (mism_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
